>>> rtl/core/utf8_validating_transcoder_top_assert.svh
// assertion macros for the utf8 transcoder blocks
// included by the modules that check their own logic, no other dependencies
`ifndef UTF8_VALIDATING_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_TRANSCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define UVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvt assertion failed");
// antecedent holds, consequent holds in the next cycle
`define UVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvt assertion failed");
`else
`define UVT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/uvt_pkg.sv
// shared types and constants of the utf8 validating transcoder
// no dependencies
`default_nettype none

package uvt_pkg;

    localparam int UVT_QUEUE_DEPTH = 4;

    // output format register values
    localparam logic FMT_UTF16 = 1'b0;
    localparam logic FMT_UTF32 = 1'b1;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [20:0] code_unit;
        logic        malformed;
        logic        last_in_run;
        logic        text_done;
    } t_out_item;

    // decoded event handed from front to back
    typedef struct packed {
        logic [20:0] value;
        logic        malformed;
        logic        text_done;
    } t_evt;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

endpackage

`default_nettype wire

>>> rtl/core/uvt_front.sv
// front end: accepts bytes, validates utf8 and gathers scalar values
// depends on uvt_pkg
`default_nettype none

module uvt_front import uvt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_evt          o_evt
);

    // allowed range of the byte after the lead byte
    localparam logic [2:0] CLS_ANY = 3'd0;
    localparam logic [2:0] CLS_E0  = 3'd1;
    localparam logic [2:0] CLS_ED  = 3'd2;
    localparam logic [2:0] CLS_F0  = 3'd3;
    localparam logic [2:0] CLS_F4  = 3'd4;

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_pending, n_pending;
    logic [2:0]  r_cls, n_cls;
    logic        r_err, n_err;

    logic [7:0]  b;
    logic        eot;
    logic        cont_ok;
    logic        bad;
    logic        ended_mid;
    logic [20:0] shifted;

    assign b   = i_item.in_byte;
    assign eot = i_item.end_of_text;
    assign shifted = {r_partial[14:0], b[5:0]};

    // continuation range check
    always_comb begin
        case (r_cls)
            CLS_E0:  cont_ok = b inside {[8'hA0:8'hBF]};
            CLS_ED:  cont_ok = b inside {[8'h80:8'h9F]};
            CLS_F0:  cont_ok = b inside {[8'h90:8'hBF]};
            CLS_F4:  cont_ok = b inside {[8'h80:8'h8F]};
            default: cont_ok = b inside {[8'h80:8'hBF]};
        endcase
    end

    // decode step
    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        n_cls     = r_cls;
        n_err     = r_err;
        bad       = 1'b0;
        ended_mid = 1'b0;
        o_push    = 1'b0;
        o_evt     = '{value: '0, malformed: 1'b0, text_done: eot};
        if (i_accept) begin
            if (r_err) begin
                if (eot) begin
                    n_err = 1'b0;
                end
            end else if (r_pending == 2'd0) begin
                if (b <= 8'h7F) begin
                    o_push      = 1'b1;
                    o_evt.value = {13'd0, b};
                end else if (b inside {[8'hC2:8'hDF]}) begin
                    n_partial = {16'd0, b[4:0]};
                    n_pending = 2'd1;
                    n_cls     = CLS_ANY;
                    ended_mid = eot;
                end else if (b inside {[8'hE0:8'hEF]}) begin
                    n_partial = {17'd0, b[3:0]};
                    n_pending = 2'd2;
                    n_cls     = (b == 8'hE0) ? CLS_E0 : (b == 8'hED) ? CLS_ED : CLS_ANY;
                    ended_mid = eot;
                end else if (b inside {[8'hF0:8'hF4]}) begin
                    n_partial = {18'd0, b[2:0]};
                    n_pending = 2'd3;
                    n_cls     = (b == 8'hF0) ? CLS_F0 : (b == 8'hF4) ? CLS_F4 : CLS_ANY;
                    ended_mid = eot;
                end else begin
                    bad = 1'b1;
                end
            end else if (cont_ok) begin
                n_cls     = CLS_ANY;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    o_push      = 1'b1;
                    o_evt.value = shifted;
                    n_partial   = '0;
                end else begin
                    n_partial = shifted;
                    ended_mid = eot;
                end
            end else begin
                bad = 1'b1;
            end

            // error result, sequence abandoned
            if (bad || ended_mid) begin
                o_push          = 1'b1;
                o_evt.value     = '0;
                o_evt.malformed = 1'b1;
                n_err           = !eot;
            end
            // any end of text or error clears the partial value, pending count and class
            if (eot || bad) begin
                n_partial = '0;
                n_pending = 2'd0;
                n_cls     = CLS_ANY;
            end
        end
    end

    // text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= 2'd0;
            r_cls     <= CLS_ANY;
            r_err     <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_cls     <= n_cls;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/uvt_queue.sv
// short event queue between front and back, register based
// depends on uvt_pkg
`default_nettype none

module uvt_queue import uvt_pkg::*; #(
    parameter int DEPTH = UVT_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_evt i_data,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_evt      o_data,
    output logic      o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_evt          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/uvt_back.sv
// back end: turns events into utf16 units or utf32 values, output register
// depends on uvt_pkg and the assertion macro header
`default_nettype none
`include "utf8_validating_transcoder_top_assert.svh"

module uvt_back import uvt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    input  wire logic i_evt_valid,
    input  wire t_evt i_evt,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    logic        r_format;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_pair;
    t_out_item   r_low;

    logic        adv;
    logic        is_pair;
    logic [19:0] off;
    t_out_item   first_item, low_item;

    assign adv     = !r_out_valid || !i_out_stall;
    assign o_pop   = adv && !r_pair && i_evt_valid;
    assign is_pair = !i_evt.malformed && (r_format == FMT_UTF16) &&
                     (i_evt.value >= SUPP_BASE);
    assign off     = 20'(i_evt.value - SUPP_BASE);

    // first result and the low half of a surrogate pair
    always_comb begin
        low_item = '{code_unit: {5'd0, LO_SURR + {6'd0, off[9:0]}},
                     malformed: 1'b0, last_in_run: 1'b1, text_done: i_evt.text_done};
        if (is_pair) begin
            first_item = '{code_unit: {5'd0, HI_SURR + {6'd0, off[19:10]}},
                           malformed: 1'b0, last_in_run: 1'b0, text_done: 1'b0};
        end else begin
            first_item = '{code_unit: i_evt.value, malformed: i_evt.malformed,
                           last_in_run: 1'b1, text_done: i_evt.text_done};
        end
    end

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_UTF16;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    // output register and pending low half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pair      <= 1'b0;
        end else if (adv) begin
            if (r_pair) begin
                r_out_valid <= 1'b1;
                r_pair      <= 1'b0;
            end else begin
                r_out_valid <= i_evt_valid;
                r_pair      <= i_evt_valid && is_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_pair) begin
                r_out <= r_low;
            end else if (i_evt_valid) begin
                r_out <= first_item;
                r_low <= low_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    `UVT_ASSERT_NOW(a_pair_has_head, i_clk, i_rst_n, r_pair, r_out_valid)
    `UVT_ASSERT_NOW(a_head_not_last, i_clk, i_rst_n, r_pair,
        !r_out.last_in_run && !r_out.text_done && !r_out.malformed)
    `UVT_ASSERT_NEXT(a_low_follows, i_clk, i_rst_n, r_pair && !i_out_stall,
        r_out_valid && r_out.last_in_run && !r_out.malformed)
    `UVT_ASSERT_NOW(a_error_zero, i_clk, i_rst_n, r_out_valid && r_out.malformed,
        r_out.code_unit == '0 && r_out.last_in_run)

endmodule

`default_nettype wire

>>> rtl/core/utf8_validating_transcoder_top.sv
// top level of the utf8 validating transcoder: front, event queue, back
// depends on uvt_pkg, uvt_front, uvt_queue, uvt_back
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//   cfg     | input     | i_cfg_we                  | i_cfg_wdata (output_format)
//
// one byte is taken every cycle while the queue has room; decode is combinational
// a result is registered as its event is popped from the queue head
// a surrogate pair gives two output items but comes from four input bytes, so
// the input keeps one byte per cycle without stalls unless the output stalls
// synchronous active-low reset clears the text state, queue and output register
// o_in_stall is high while the queue is full; the output register holds under stall
`default_nettype none

module utf8_validating_transcoder_top import uvt_pkg::*; #(
    parameter int QUEUE_DEPTH = UVT_QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    logic in_accept;
    logic push, pop, q_valid, q_full;
    t_evt push_evt, head_evt;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // byte decode
    uvt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_evt    (push_evt)
    );

    // event queue
    uvt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_evt),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_evt),
        .o_full  (q_full)
    );

    // result formatting
    uvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt_valid (q_valid),
        .i_evt       (head_evt),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
